// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Implication checked in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/btbp_pkg.sv =====
// Types and constants for the branch target buffer predictor.
package btbp_pkg;

  localparam int WORD_W = 32;
  localparam int OPC_W  = 7;

  // Entry count; a power of two, so the entry is the low address bits.
  localparam int BUFFER_ENTRIES = 4;
  localparam int IDX_W          = $clog2(BUFFER_ENTRIES);

  localparam logic [OPC_W-1:0] OPC_BRANCH = 7'h63;
  localparam logic [OPC_W-1:0] OPC_JAL    = 7'h6f;
  localparam logic [OPC_W-1:0] OPC_JALR   = 7'h67;
  localparam int               SIGN_BIT   = 31;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Classification of one beat.
  typedef struct packed {
    logic accepted;
    logic illegal;
    logic legal;
    logic is_branch;
    logic is_jump;
    logic backward;
  } btbp_class_t;

  // Running statistics.
  typedef struct packed {
    word_t accesses;
    word_t hits;
    word_t misses;
    word_t branches;
    word_t jumps;
    word_t taken_branches;
    word_t taken_jumps;
  } btbp_counts_t;

endpackage

// ===== sv/btbp_ifs.sv =====
// Valid/ready channel interfaces for records and results.
interface btbp_in_if;
  logic             valid;
  logic             ready;
  btbp_pkg::word_t  instr_word;
  btbp_pkg::word_t  instr_addr;
  btbp_pkg::word_t  actual_target;
  logic             actual_taken;

  modport source (output valid, instr_word, instr_addr, actual_target, actual_taken,
                  input ready);
  modport sink   (input valid, instr_word, instr_addr, actual_target, actual_taken,
                  output ready);
endinterface

interface btbp_out_if;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic             illegal;
  logic             predicted_taken;
  btbp_pkg::word_t  target_guess;
  logic             prediction_correct;
  btbp_pkg::word_t  access_count;
  btbp_pkg::word_t  correct_count;
  btbp_pkg::word_t  mispredict_count;
  btbp_pkg::word_t  branch_count;
  btbp_pkg::word_t  jump_count;
  btbp_pkg::word_t  taken_branch_count;
  btbp_pkg::word_t  taken_jump_count;

  modport source (output valid, accepted, illegal, predicted_taken, target_guess,
                  prediction_correct, access_count, correct_count, mispredict_count,
                  branch_count, jump_count, taken_branch_count, taken_jump_count,
                  input ready);
  modport sink   (input valid, accepted, illegal, predicted_taken, target_guess,
                  prediction_correct, access_count, correct_count, mispredict_count,
                  branch_count, jump_count, taken_branch_count, taken_jump_count,
                  output ready);
endinterface

// ===== sv/btbp_decode.sv =====
// Opcode decode and legality check of one control-transfer record.
module btbp_decode (
  input  btbp_pkg::word_t      instr_word,
  input  logic                 actual_taken,
  output btbp_pkg::btbp_class_t cls
);

  logic [btbp_pkg::OPC_W-1:0] opc;

  assign opc = instr_word[btbp_pkg::OPC_W-1:0];

  always_comb begin
    cls.accepted  = (instr_word != '0);
    cls.is_branch = (opc == btbp_pkg::OPC_BRANCH);
    cls.is_jump   = (opc == btbp_pkg::OPC_JAL) || (opc == btbp_pkg::OPC_JALR);
    cls.backward  = instr_word[btbp_pkg::SIGN_BIT];
    // a not-taken jump is as bad as a non-transfer
    cls.legal     = cls.accepted && (cls.is_branch || (cls.is_jump && actual_taken));
    cls.illegal   = cls.accepted && !cls.legal;
  end

endmodule

// ===== sv/btbp_table.sv =====
// Target buffer: valid bits and stored targets, one read and one write port.
module btbp_table (
  input  logic             clk,
  input  logic             rst,
  input  btbp_pkg::idx_t   idx,
  input  logic             wr_en,
  input  btbp_pkg::word_t  wr_target,
  output logic             rd_valid,
  output btbp_pkg::word_t  rd_target
);

  logic [btbp_pkg::BUFFER_ENTRIES-1:0] valid;
  btbp_pkg::word_t                     target [btbp_pkg::BUFFER_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      target[idx] <= wr_target;
    end
  end

  assign rd_valid  = valid[idx];
  assign rd_target = target[idx];

endmodule

// ===== sv/btbp_stats.sv =====
// Seven wrapping statistics counters.
module btbp_stats (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   upd,
  input  logic                   is_branch,
  input  logic                   taken,
  input  logic                   hit,
  output btbp_pkg::btbp_counts_t counts
);

  btbp_pkg::btbp_counts_t counts_next;

  always_comb begin
    counts_next = counts;
    if (upd) begin
      counts_next.accesses = counts.accesses + 32'd1;
      if (hit) begin
        counts_next.hits = counts.hits + 32'd1;
      end else begin
        counts_next.misses = counts.misses + 32'd1;
      end
      if (is_branch) begin
        counts_next.branches = counts.branches + 32'd1;
        if (taken) begin
          counts_next.taken_branches = counts.taken_branches + 32'd1;
        end
      end else begin
        // only taken jumps get this far
        counts_next.jumps       = counts.jumps + 32'd1;
        counts_next.taken_jumps = counts.taken_jumps + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else begin
      counts <= counts_next;
    end
  end

endmodule

// ===== sv/branch_target_buffer_predictor.sv =====
// Branch target buffer predictor, backward-taken policy: top level.
// Path from input beat to result beat: input register, then result register.
// Throughput: one beat per cycle; input ready drops only while the input
// register is full and the result register is held by the sink.
// Reset (rst, synchronous): clears buffer valid bits, all counters and both valid flags.
// Stored targets are not reset; an entry's target is never used before its valid bit is set.
`include "assert_macros.svh"

module branch_target_buffer_predictor (
  input logic        clk,
  input logic        rst,
  btbp_in_if.sink    item,
  btbp_out_if.source result
);

  // Input register
  logic            s1_valid;
  btbp_pkg::word_t s1_word;
  btbp_pkg::word_t s1_addr;
  btbp_pkg::word_t s1_target;
  logic            s1_taken;

  // Result register
  logic            res_valid;
  logic            res_accepted;
  logic            res_illegal;
  logic            res_pred;
  btbp_pkg::word_t res_ptgt;
  logic            res_ok;

  btbp_pkg::btbp_class_t  cls;
  btbp_pkg::btbp_counts_t counts;
  btbp_pkg::idx_t         idx;

  logic            advance;   // result slot free at this edge
  logic            fire;      // input register moves into result register
  logic            tbl_valid;
  btbp_pkg::word_t tbl_target;
  logic            pred;
  btbp_pkg::word_t ptgt;
  logic            ok;

  assign advance    = !res_valid || result.ready;
  assign fire       = s1_valid && advance;
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_word   <= item.instr_word;
      s1_addr   <= item.instr_addr;
      s1_target <= item.actual_target;
      s1_taken  <= item.actual_taken;
    end
  end

  btbp_decode u_decode (
    .instr_word   (s1_word),
    .actual_taken (s1_taken),
    .cls          (cls)
  );

  // entry = address modulo entry count (power of two)
  assign idx = s1_addr[btbp_pkg::IDX_W-1:0];

  // Lookup sees the table before this beat's write, which lands at the same edge.
  btbp_table u_table (
    .clk       (clk),
    .rst       (rst),
    .idx       (idx),
    .wr_en     (fire && cls.legal && cls.is_branch && s1_taken),
    .wr_target (s1_target),
    .rd_valid  (tbl_valid),
    .rd_target (tbl_target)
  );

  // Prediction and scoring; all zero unless the record is legal
  always_comb begin
    pred = cls.legal && cls.is_branch && cls.backward && tbl_valid;
    ptgt = (cls.legal && tbl_valid) ? tbl_target : '0;
    ok   = cls.legal && ((pred && s1_taken && (ptgt == s1_target)) || (!pred && !s1_taken));
  end

  btbp_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .upd       (fire && cls.legal),
    .is_branch (cls.is_branch),
    .taken     (s1_taken),
    .hit       (ok),
    .counts    (counts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_accepted <= cls.accepted;
      res_illegal  <= cls.illegal;
      res_pred     <= pred;
      res_ptgt     <= ptgt;
      res_ok       <= ok;
    end
  end

  // Counters change only when a new result loads, so the live counters
  // always match the held result beat.
  assign result.valid              = res_valid;
  assign result.accepted           = res_accepted;
  assign result.illegal            = res_illegal;
  assign result.predicted_taken    = res_pred;
  assign result.target_guess       = res_ptgt;
  assign result.prediction_correct = res_ok;
  assign result.access_count       = counts.accesses;
  assign result.correct_count      = counts.hits;
  assign result.mispredict_count   = counts.misses;
  assign result.branch_count       = counts.branches;
  assign result.jump_count         = counts.jumps;
  assign result.taken_branch_count = counts.taken_branches;
  assign result.taken_jump_count   = counts.taken_jumps;

  // Every scored beat is either a hit or a miss
  `ASSERT_ALWAYS(a_hit_miss_sum, clk, rst,
    32'(counts.hits + counts.misses) == counts.accesses)
  // Every scored beat is a branch or a jump
  `ASSERT_ALWAYS(a_kind_sum, clk, rst,
    32'(counts.branches + counts.jumps) == counts.accesses)
  // Only taken jumps are scored
  `ASSERT_ALWAYS(a_jumps_taken, clk, rst, counts.jumps == counts.taken_jumps)
  // An illegal or ignored record makes no prediction
  `ASSERT_IMPLIES(a_no_pred_illegal, clk, rst,
    res_valid && (res_illegal || !res_accepted), !res_pred && !res_ok && (res_ptgt == '0))

endmodule
